// File: rtl/q2e_pkg.sv
// Package for the quaternion to Euler converter: widths, CORDIC tables and helpers.
`default_nettype none
package q2e_pkg;

  localparam int unsigned QW = 16;
  // Q.28 operands of atan2 and the CORDIC datapath width.
  localparam int unsigned DW = 36;
  localparam int unsigned AW = 32;
  localparam int unsigned MaxSteps = 24;
  localparam int unsigned SqW = 58;

  localparam logic signed [AW-1:0] HalfPiQ28 = 32'sd421657428;
  localparam logic signed [DW-1:0] OneQ28 = 36'sd268435456;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_at(input logic [4:0] i);
    logic signed [AW-1:0] r;
    case (i)
      5'd0: r = 32'sd210828714;
      5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;
      5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755422;
      5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;
      5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;
      5'd9: r = 32'sd524287;
      default: r = 32'sd262144 >>> (i - 5'd10);
    endcase
    return r;
  endfunction

  // Round Q.28 to Q3.13 (ties up) and clamp to +-lim.
  function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [AW:0] t;
    logic signed [AW:0] r;
    t = {z[AW-1], z} + (AW+1)'(16384);
    r = t >>> 15;
    if (r > (AW+1)'(lim)) return lim;
    if (r < -(AW+1)'(lim)) return -lim;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/quaternion_to_euler.sv
// Top level: quaternion to roll, pitch and yaw via pipelined CORDIC cells.
//
//   port group   dir  bits  contents
//   s_axis_*     in   64    quat_x, quat_y, quat_z, quat_w
//   m_axis_*     out  48    roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One word per cycle while the output is not stalled. Stages: products, sums,
// squaring, the 29-cell square root chain, pre-rotation, CORDIC row, rounding.
// The whole pipe advances when the output register is empty or being taken,
// so a stall on the output holds every stage. Reset clears only valid bits.
`default_nettype none
module quaternion_to_euler #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] quat_x, [31:16] quat_y, [47:32] quat_z, [63:48] quat_w
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] roll_angle, [30:16] pitch_angle, [46:31] yaw_angle,
  // [47] pitch_clamped
  output logic [47:0]      m_axis_tdata
);
  localparam int unsigned Steps = (CORDIC_STEPS > q2e_pkg::MaxSteps) ?
                                  q2e_pkg::MaxSteps : CORDIC_STEPS;
  localparam int unsigned SqN = 29;
  localparam int unsigned Lat = 3 + SqN + 1 + Steps;
  localparam int unsigned DW = q2e_pkg::DW;
  localparam int unsigned SqW = q2e_pkg::SqW;

  logic adv;
  logic [Lat-1:0] vld_q;
  logic out_v_q;
  logic [47:0] out_q;

  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_v_q <= vld_q[Lat-1];
    end
  end

  // Stage 1: products.
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = s_axis_tdata[15:0];
  assign qy = s_axis_tdata[31:16];
  assign qz = s_axis_tdata[47:32];
  assign qw = s_axis_tdata[63:48];
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q,
                      p_wy_q, p_zx_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_wx_q <= qw * qx; p_yz_q <= qy * qz; p_xx_q <= qx * qx;
      p_yy_q <= qy * qy; p_wz_q <= qw * qz; p_xy_q <= qx * qy;
      p_zz_q <= qz * qz; p_wy_q <= qw * qy; p_zx_q <= qz * qx;
    end
  end

  // Stage 2: sums.
  logic signed [DW-1:0] rn_q, rd_q, yn_q, yd_q, s_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn_q <= (DW'(p_wx_q) + DW'(p_yz_q)) <<< 1;
      rd_q <= q2e_pkg::OneQ28 - ((DW'(p_xx_q) + DW'(p_yy_q)) <<< 1);
      yn_q <= (DW'(p_wz_q) + DW'(p_xy_q)) <<< 1;
      yd_q <= q2e_pkg::OneQ28 - ((DW'(p_yy_q) + DW'(p_zz_q)) <<< 1);
      s_q  <= (DW'(p_wy_q) - DW'(p_zx_q)) <<< 1;
    end
  end

  // Stage 3: s squared for the cosine; the clamp decision.
  logic [DW-1:0] mag;
  logic clamp3;
  assign mag = s_q[DW-1] ? DW'(-s_q) : DW'(s_q);
  assign clamp3 = mag >= DW'(q2e_pkg::OneQ28);
  logic [SqW-1:0] rad_q;
  logic signed [DW-1:0] rn3_q, rd3_q, yn3_q, yd3_q, s3_q;
  logic clamp3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q <= clamp3 ? '0 : (SqW'(1) << 56) - SqW'(mag[28:0]) * SqW'(mag[28:0]);
      rn3_q <= rn_q; rd3_q <= rd_q; yn3_q <= yn_q; yd3_q <= yd_q; s3_q <= s_q;
      clamp3_q <= clamp3;
    end
  end

  // Square root chain, with the other operands delayed alongside.
  logic [SqW-1:0] rem_c [SqN+1];
  logic [SqW-1:0] res_c [SqN+1];
  logic signed [DW-1:0] dly_rn [SqN+1], dly_rd [SqN+1], dly_yn [SqN+1],
                        dly_yd [SqN+1], dly_s [SqN+1];
  logic dly_cl [SqN+1];
  assign rem_c[0] = rad_q;
  assign res_c[0] = '0;
  assign dly_rn[0] = rn3_q; assign dly_rd[0] = rd3_q; assign dly_yn[0] = yn3_q;
  assign dly_yd[0] = yd3_q; assign dly_s[0] = s3_q; assign dly_cl[0] = clamp3_q;
  for (genvar k = 0; k < SqN; k++) begin : g_sq
    q2e_sqrt_cell #(.Bit(SqN - 1 - k)) u_sq (
      .clk_i, .en_i(adv), .rem_i(rem_c[k]), .res_i(res_c[k]),
      .rem_o(rem_c[k+1]), .res_o(res_c[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dly_rn[k+1] <= dly_rn[k]; dly_rd[k+1] <= dly_rd[k];
        dly_yn[k+1] <= dly_yn[k]; dly_yd[k+1] <= dly_yd[k];
        dly_s[k+1] <= dly_s[k]; dly_cl[k+1] <= dly_cl[k];
      end
    end
  end

  // Pre-rotation into the right half plane.
  function automatic q2e_pkg::cordic_t pre(input logic signed [DW-1:0] y,
                                           input logic signed [DW-1:0] x);
    q2e_pkg::cordic_t r;
    r.x = x; r.y = y; r.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y; r.y = -x; r.z = q2e_pkg::HalfPiQ28;
      end else begin
        r.x = -y; r.y = x; r.z = -q2e_pkg::HalfPiQ28;
      end
    end
    return r;
  endfunction

  q2e_pkg::cordic_t cr [Steps+1], cy [Steps+1], cp [Steps+1];
  logic zr [Steps+1], zy [Steps+1], cl [Steps+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr[0] <= pre(dly_rn[SqN], dly_rd[SqN]);
      cy[0] <= pre(dly_yn[SqN], dly_yd[SqN]);
      cp[0] <= pre(dly_s[SqN], DW'(res_c[SqN][28:0]));
      zr[0] <= dly_rn[SqN] == '0 && dly_rd[SqN] == '0;
      zy[0] <= dly_yn[SqN] == '0 && dly_yd[SqN] == '0;
      cl[0] <= dly_cl[SqN];
    end
  end
  // Pitch when clamped: sign of s.
  logic ps [Steps+1];
  always_ff @(posedge clk_i) begin
    if (adv) ps[0] <= dly_s[SqN] > 0;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_cd
    q2e_cordic_cell #(.Step(k)) u_r (.clk_i, .d_i(cr[k]), .en_i(adv), .q_o(cr[k+1]));
    q2e_cordic_cell #(.Step(k)) u_y (.clk_i, .d_i(cy[k]), .en_i(adv), .q_o(cy[k+1]));
    q2e_cordic_cell #(.Step(k)) u_p (.clk_i, .d_i(cp[k]), .en_i(adv), .q_o(cp[k+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        zr[k+1] <= zr[k]; zy[k+1] <= zy[k]; cl[k+1] <= cl[k]; ps[k+1] <= ps[k];
      end
    end
  end

  logic signed [15:0] roll_a, yaw_a, pitch_a;
  always_comb begin
    roll_a = zr[Steps] ? 16'sd0 : q2e_pkg::to_q13(cr[Steps].z, q2e_pkg::PiQ13);
    yaw_a = zy[Steps] ? 16'sd0 : q2e_pkg::to_q13(cy[Steps].z, q2e_pkg::PiQ13);
    if (cl[Steps]) pitch_a = ps[Steps] ? q2e_pkg::HalfPiQ13 : -q2e_pkg::HalfPiQ13;
    else pitch_a = q2e_pkg::to_q13(cp[Steps].z, q2e_pkg::HalfPiQ13);
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {cl[Steps], yaw_a, pitch_a[14:0], roll_a};
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
endmodule
`default_nettype wire

// File: rtl/q2e_cordic_cell.sv
// One CORDIC vectoring cell: one micro-rotation, registered.
`default_nettype none
module q2e_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic               clk_i,
  input  wire q2e_pkg::cordic_t   d_i,
  input  wire logic               en_i,
  output q2e_pkg::cordic_t        q_o
);
  q2e_pkg::cordic_t n_d, n_q;
  logic signed [q2e_pkg::DW-1:0] xs, ys;
  localparam logic [4:0] StepIdx = 5'(Step);

  always_comb begin
    xs = d_i.x >>> Step;
    ys = d_i.y >>> Step;
    if (d_i.y > 0) begin
      n_d.x = d_i.x + ys;
      n_d.y = d_i.y - xs;
      n_d.z = d_i.z + q2e_pkg::atan_at(StepIdx);
    end else begin
      n_d.x = d_i.x - ys;
      n_d.y = d_i.y + xs;
      n_d.z = d_i.z - q2e_pkg::atan_at(StepIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) n_q <= n_d;
  end
  assign q_o = n_q;
endmodule
`default_nettype wire

// File: rtl/q2e_sqrt_cell.sv
// One stage of a restoring square root: two radicand bits, one root bit.
`default_nettype none
module q2e_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [q2e_pkg::SqW-1:0]     rem_i,
  input  wire logic [q2e_pkg::SqW-1:0]     res_i,
  output logic [q2e_pkg::SqW-1:0]          rem_o,
  output logic [q2e_pkg::SqW-1:0]          res_o
);
  localparam logic [q2e_pkg::SqW-1:0] BitV = q2e_pkg::SqW'(1) << (2*Bit);
  logic [q2e_pkg::SqW-1:0] rem_d, res_d, rem_q, res_q, trial;
  always_comb begin
    trial = res_i + BitV;
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      res_d = (res_i >> 1) + BitV;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end
  assign rem_o = rem_q;
  assign res_o = res_q;
endmodule
`default_nettype wire
